/* hdl/assert_macros.svh */
// Assertion macros used by the checker module of the line stepper.
// No dependencies; include by bare file name inside a module body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while the synchronous reset is low.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while the synchronous reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

/* hdl/bls_pkg.sv */
// Package for the Bresenham line stepper: widths, action codes, the line state type and a move helper.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bls_pkg;

    localparam int COORD_BITS = 10;
    localparam int DEC_BITS   = COORD_BITS + 3;
    localparam int STEP_BITS  = COORD_BITS + 1;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    typedef logic [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        t_coord                     cur_x;
        t_coord                     cur_y;
        logic signed [DEC_BITS-1:0] decision;
        t_coord                     major_delta;
        t_coord                     minor_delta;
        logic [STEP_BITS-1:0]       steps_left;
        logic                       x_dir_neg;
        logic                       y_dir_neg;
        logic                       steep;
        logic                       busy;
    } t_line_state;

    // One pixel forward or back along an axis, wrapping at the coordinate width.
    function automatic t_coord move_coord(input t_coord c, input logic neg);
        move_coord = neg ? (c - t_coord'(1)) : (c + t_coord'(1));
    endfunction

endpackage

/* hdl/bls_setup.sv */
// Line setup: directions, absolute deltas, steep swap and the first decision value.
// Depends on bls_pkg.
`timescale 1ns / 1ps

module bls_setup
    import bls_pkg::*;
(
    input  t_coord      i_x_start,
    input  t_coord      i_y_start,
    input  t_coord      i_x_end,
    input  t_coord      i_y_end,
    output t_line_state o_line
);

    logic   x_neg;
    logic   y_neg;
    t_coord adx;
    t_coord ady;
    logic   steep;
    t_coord major;
    t_coord minor;

    always_comb begin
        x_neg = i_x_end < i_x_start;
        y_neg = i_y_end < i_y_start;
        adx   = x_neg ? (i_x_start - i_x_end) : (i_x_end - i_x_start);
        ady   = y_neg ? (i_y_start - i_y_end) : (i_y_end - i_y_start);
        steep = ady > adx;
        major = steep ? ady : adx;
        minor = steep ? adx : ady;

        o_line.cur_x       = i_x_start;
        o_line.cur_y       = i_y_start;
        o_line.decision    = $signed({2'b00, minor, 1'b0}) - $signed({3'b000, major});
        o_line.major_delta = major;
        o_line.minor_delta = minor;
        o_line.steps_left  = {1'b0, major};
        o_line.x_dir_neg   = x_neg;
        o_line.y_dir_neg   = y_neg;
        o_line.steep       = steep;
        o_line.busy        = major != '0;
    end

endmodule

/* hdl/bls_step.sv */
// One Bresenham step: major-axis move, optional minor-axis move, decision update.
// Depends on bls_pkg.
`timescale 1ns / 1ps

module bls_step
    import bls_pkg::*;
(
    input  t_line_state i_line,
    output t_line_state o_line
);

    logic                       minor_move;
    logic signed [DEC_BITS-1:0] two_minor;
    logic signed [DEC_BITS-1:0] two_major;
    logic [STEP_BITS-1:0]       steps;

    always_comb begin
        minor_move = ~i_line.decision[DEC_BITS-1];
        two_minor  = $signed({2'b00, i_line.minor_delta, 1'b0});
        two_major  = $signed({2'b00, i_line.major_delta, 1'b0});
        steps      = i_line.steps_left - STEP_BITS'(1);

        o_line = i_line;
        if (i_line.steep || minor_move) begin
            o_line.cur_y = move_coord(i_line.cur_y, i_line.y_dir_neg);
        end
        if (!i_line.steep || minor_move) begin
            o_line.cur_x = move_coord(i_line.cur_x, i_line.x_dir_neg);
        end
        if (minor_move) begin
            o_line.decision = i_line.decision + two_minor - two_major;
        end else begin
            o_line.decision = i_line.decision + two_minor;
        end
        o_line.steps_left = steps;
        o_line.busy       = steps != '0;
    end

endmodule

/* hdl/bresenham_line_stepper.sv */
// Top level of the Bresenham line stepper: line state, result register, handshakes.
// Depends on bls_pkg, bls_setup and bls_step.
//
//   Channel  Direction  Handshake            Payload
//   -------  ---------  -------------------  -----------------------------------------
//   item     in         i_valid / o_stall    i_action, i_x_start, i_y_start, i_x_end, i_y_end
//   pixel    out        o_valid / i_stall    o_pixel_x, o_pixel_y, o_pixel_valid, o_last_pixel
//
// Every accepted beat gives exactly one pixel beat, in the next clock cycle.
// A new beat is taken in every cycle unless o_stall is high, so the block sustains one
// pixel per clock without stalls, set by the single result register after the step logic.
// Reset (i_rst_n low at a clock edge) clears the line state, so the block starts idle.
// When the result register is full and the sink stalls, o_stall goes high and the
// line state holds until the pending pixel beat is taken.
`timescale 1ns / 1ps

module bresenham_line_stepper
    import bls_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_stall,
    input  logic   i_action,
    input  t_coord i_x_start,
    input  t_coord i_y_start,
    input  t_coord i_x_end,
    input  t_coord i_y_end,
    output logic   o_valid,
    input  logic   i_stall,
    output t_coord o_pixel_x,
    output t_coord o_pixel_y,
    output logic   o_pixel_valid,
    output logic   o_last_pixel
);

    // Current line: position, decision value, deltas, directions and busy flag.
    t_line_state r_line;
    t_line_state n_line;
    t_line_state start_line;
    t_line_state step_line;

    // Result register holding one pixel beat.
    logic   r_out_valid;
    t_coord r_pixel_x;
    t_coord r_pixel_y;
    logic   r_pixel_valid;
    logic   r_last_pixel;
    t_coord n_pixel_x;
    t_coord n_pixel_y;
    logic   n_pixel_valid;
    logic   n_last_pixel;

    logic accept;

    // The input side is held back only while a finished pixel waits on a stalled sink.
    assign o_stall = r_out_valid & i_stall;
    assign accept  = i_valid & ~o_stall;

    bls_setup u_setup (
        .i_x_start (i_x_start),
        .i_y_start (i_y_start),
        .i_x_end   (i_x_end),
        .i_y_end   (i_y_end),
        .o_line    (start_line)
    );

    bls_step u_step (
        .i_line (r_line),
        .o_line (step_line)
    );

    // Choose what this beat does to the line and which pixel it reports.
    // A start always wins, even over a line still in progress. A step while idle
    // reports an empty pixel and leaves the line untouched.
    always_comb begin
        n_line        = r_line;
        n_pixel_x     = '0;
        n_pixel_y     = '0;
        n_pixel_valid = 1'b0;
        n_last_pixel  = 1'b0;
        if (i_action == ACT_START) begin
            n_line        = start_line;
            n_pixel_x     = start_line.cur_x;
            n_pixel_y     = start_line.cur_y;
            n_pixel_valid = 1'b1;
            n_last_pixel  = ~start_line.busy;
        end else if (r_line.busy) begin
            n_line        = step_line;
            n_pixel_x     = step_line.cur_x;
            n_pixel_y     = step_line.cur_y;
            n_pixel_valid = 1'b1;
            n_last_pixel  = ~step_line.busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_line      <= n_line;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Pixel payload is loaded only with an accepted beat, so it holds under a stall.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pixel_x     <= n_pixel_x;
            r_pixel_y     <= n_pixel_y;
            r_pixel_valid <= n_pixel_valid;
            r_last_pixel  <= n_last_pixel;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_pixel_x     = r_pixel_x;
    assign o_pixel_y     = r_pixel_y;
    assign o_pixel_valid = r_pixel_valid;
    assign o_last_pixel  = r_last_pixel;

endmodule

/* hdl/bls_checker.sv */
// Port-level checker for the Bresenham line stepper, attached by bind.
// Depends on bls_pkg and assert_macros.svh.
`timescale 1ns / 1ps

module bls_checker
    import bls_pkg::*;
(
    input logic   i_clk,
    input logic   i_rst_n,
    input logic   i_valid,
    input logic   o_stall,
    input logic   i_action,
    input t_coord i_x_start,
    input t_coord i_y_start,
    input t_coord i_x_end,
    input t_coord i_y_end,
    input logic   o_valid,
    input logic   i_stall,
    input t_coord o_pixel_x,
    input t_coord o_pixel_y,
    input logic   o_pixel_valid,
    input logic   o_last_pixel
);

`include "assert_macros.svh"

    logic in_beat;
    logic single_point;

    assign in_beat      = i_valid & ~o_stall;
    assign single_point = (i_action == ACT_START) && (i_x_start == i_x_end)
                          && (i_y_start == i_y_end);

    // A pixel beat that waits on a stalled sink stays offered.
    `ASSERT_NEXT(a_out_holds, i_clk, i_rst_n, o_valid && i_stall, o_valid)

    // Every accepted item shows up as a pixel beat in the next cycle.
    `ASSERT_NEXT(a_beat_answered, i_clk, i_rst_n, in_beat, o_valid)

    // An empty pixel carries no position and no end mark.
    `ASSERT_IMPLY(a_empty_pixel, i_clk, i_rst_n, o_valid && !o_pixel_valid,
        !o_last_pixel && o_pixel_x == '0 && o_pixel_y == '0)

    // A line whose endpoints coincide is one pixel, its own end point.
    `ASSERT_NEXT(a_single_point, i_clk, i_rst_n, in_beat && single_point,
        o_pixel_valid && o_last_pixel && o_pixel_x == $past(i_x_start)
        && o_pixel_y == $past(i_y_start))

    // Any start reports its first endpoint as a real pixel.
    `ASSERT_NEXT(a_start_pixel, i_clk, i_rst_n, in_beat && i_action == ACT_START,
        o_pixel_valid && o_pixel_x == $past(i_x_start) && o_pixel_y == $past(i_y_start))

endmodule

bind bresenham_line_stepper bls_checker u_bls_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .i_action      (i_action),
    .i_x_start     (i_x_start),
    .i_y_start     (i_y_start),
    .i_x_end       (i_x_end),
    .i_y_end       (i_y_end),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_pixel_x     (o_pixel_x),
    .o_pixel_y     (o_pixel_y),
    .o_pixel_valid (o_pixel_valid),
    .o_last_pixel  (o_last_pixel)
);
